/* sv/dip_pkg.sv */
// Shared types and constants for the DIP cache replacement block.
package dip_pkg;

  // Selector range and midpoint.
  localparam int unsigned SelW = 10;
  localparam logic [SelW-1:0] SelMid = 10'd512;
  localparam logic [SelW-1:0] SelMax = 10'd1023;

  // Dueling period and BIP throttle width.
  localparam int unsigned DuelBits = 5;
  localparam int unsigned BipW = 5;
  localparam int unsigned HitCntW = 32;

  // Set role codes.
  typedef enum logic [1:0] {
    ROLE_FOLLOW  = 2'd0,
    ROLE_LRU_LDR = 2'd1,
    ROLE_BIP_LDR = 2'd2
  } role_e;

  // One result item.
  typedef struct packed {
    logic                hit;
    logic                used_bip;
    logic [HitCntW-1:0]  hit_count;
  } result_t;

endpackage

/* sv/dip_if.sv */
// Valid/ready channel interfaces for the DIP cache replacement block.
interface dip_addr_if #(
  parameter int unsigned ADDR_BITS = 48
) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface dip_res_if ();
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          used_bip;
  logic [dip_pkg::HitCntW-1:0]   hit_count;

  modport source (output valid, output hit, output used_bip, output hit_count, input ready);
  modport sink   (input valid, input hit, input used_bip, input hit_count, output ready);
endinterface

/* sv/dip_front.sv */
// Front end: accepts addresses, splits set and tag, classifies set role, queues them.
module dip_front #(
  parameter int unsigned ADDR_BITS   = 48,
  parameter int unsigned OFFSET_BITS = 6,
  parameter int unsigned SET_BITS    = 10,
  parameter int unsigned TAG_W       = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ADDR_BITS-1:0] in_addr_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output logic [SET_BITS-1:0]  q_set_o,
  output logic [TAG_W-1:0]     q_tag_o,
  output dip_pkg::role_e       q_role_o
);

  // Two-entry queue.
  logic [SET_BITS-1:0]  set_q [2];
  logic [TAG_W-1:0]     tag_q [2];
  dip_pkg::role_e       role_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;

  logic [SET_BITS-1:0]  set_c;
  logic [TAG_W-1:0]     tag_c;
  dip_pkg::role_e       role_c;
  logic                 push, pop;

  // Split the address and classify the set.
  always_comb begin
    set_c = in_addr_i[OFFSET_BITS +: SET_BITS];
    tag_c = in_addr_i[ADDR_BITS-1 -: TAG_W];
    if (set_c[dip_pkg::DuelBits-1:0] == '0) begin
      role_c = dip_pkg::ROLE_LRU_LDR;
    end else if (set_c[dip_pkg::DuelBits-1:0] == dip_pkg::DuelBits'(1)) begin
      role_c = dip_pkg::ROLE_BIP_LDR;
    end else begin
      role_c = dip_pkg::ROLE_FOLLOW;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_set_o    = set_q[rd_ptr_q];
  assign q_tag_o    = tag_q[rd_ptr_q];
  assign q_role_o   = role_q[rd_ptr_q];

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Store payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      set_q[wr_ptr_q]  <= set_c;
      tag_q[wr_ptr_q]  <= tag_c;
      role_q[wr_ptr_q] <= role_c;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_ready_o)
    else $error("full queue accepts");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !push) |=> !q_valid_o)
    else $error("empty queue shows item");

endmodule

/* sv/dip_back.sv */
// Back end: clearing pass, set read, tag compare, recency update, dueling counters, result register.
module dip_back #(
  parameter int unsigned NUM_SETS = 1024,
  parameter int unsigned WAYS     = 16,
  parameter int unsigned SET_BITS = 10,
  parameter int unsigned TAG_W    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  logic [SET_BITS-1:0]           q_set_i,
  input  logic [TAG_W-1:0]              q_tag_i,
  input  dip_pkg::role_e                q_role_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output dip_pkg::result_t              res_o
);

  localparam int unsigned WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RankW = WayW;
  localparam int unsigned CntW  = $clog2(WAYS + 1);

  // State codes.
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StClear = 2'd2;

  // Row memories: one row per set.
  logic [WAYS*TAG_W-1:0]  tag_mem  [NUM_SETS];
  logic [WAYS*RankW-1:0]  rank_mem [NUM_SETS];
  logic [WAYS-1:0]        vld_mem  [NUM_SETS];

  logic [1:0]             st_q;
  logic [SET_BITS-1:0]    clr_q;
  logic [SET_BITS-1:0]    set_q;
  logic [TAG_W-1:0]       tag_q;
  dip_pkg::role_e         role_q;
  logic [WAYS*TAG_W-1:0]  tag_row_q;
  logic [WAYS*RankW-1:0]  rank_row_q;
  logic [WAYS-1:0]        vld_row_q;

  logic [dip_pkg::SelW-1:0]    sel_q;
  logic [dip_pkg::BipW-1:0]    bip_q;
  logic [dip_pkg::HitCntW-1:0] hits_q;
  logic                        res_v_q;
  dip_pkg::result_t            res_q;

  // Combinational update of one row.
  logic                   bip_c, hit_c, full_c, at_mru_c;
  logic [WayW-1:0]        hit_way_c, slot_c;
  logic [RankW-1:0]       hit_rank_c;
  logic [CntW-1:0]        n_c;
  logic [dip_pkg::BipW-1:0] bip_next_c;
  logic [WAYS*RankW-1:0]  rank_new_c;
  logic [WAYS-1:0]        vld_new_c;
  logic                   do_exec;

  assign do_exec  = (st_q == StRead) && (!res_v_q || res_ready_i);
  assign q_pop_o  = (st_q == StIdle) && q_valid_i;

  always_comb begin
    logic [RankW-1:0] r;
    bip_c = (role_q == dip_pkg::ROLE_BIP_LDR) ||
            ((role_q == dip_pkg::ROLE_FOLLOW) && (sel_q > dip_pkg::SelMid));
    hit_c = 1'b0; hit_way_c = '0; hit_rank_c = '0; n_c = '0;
    slot_c = '0; r = '0;
    // Compare tags and count valid ways.
    for (int w = 0; w < WAYS; w++) begin
      if (vld_row_q[w]) begin
        n_c = n_c + CntW'(1);
        if (tag_row_q[w*TAG_W +: TAG_W] == tag_q) begin
          hit_c = 1'b1;
          hit_way_c = WayW'(w);
          hit_rank_c = rank_row_q[w*RankW +: RankW];
        end
      end
    end
    full_c = (n_c == CntW'(WAYS));
    // Pick victim or lowest invalid way.
    for (int w = WAYS-1; w >= 0; w--) begin
      if (!vld_row_q[w]) begin
        slot_c = WayW'(w);
      end
    end
    if (full_c) begin
      slot_c = '0;
      for (int w = 0; w < WAYS; w++) begin
        if (rank_row_q[w*RankW +: RankW] == RankW'(WAYS-1)) slot_c = WayW'(w);
      end
    end
    bip_next_c = bip_q + dip_pkg::BipW'(1);
    at_mru_c   = !bip_c || (bip_next_c == '0);
    rank_new_c = rank_row_q;
    vld_new_c  = vld_row_q;
    if (hit_c) begin
      for (int w = 0; w < WAYS; w++) begin
        r = rank_row_q[w*RankW +: RankW];
        if (vld_row_q[w] && r < hit_rank_c) rank_new_c[w*RankW +: RankW] = r + RankW'(1);
      end
      rank_new_c[hit_way_c*RankW +: RankW] = '0;
    end else begin
      if (full_c) vld_new_c[slot_c] = 1'b0;
      if (at_mru_c) begin
        for (int w = 0; w < WAYS; w++) begin
          if (vld_new_c[w])
            rank_new_c[w*RankW +: RankW] = rank_row_q[w*RankW +: RankW] + RankW'(1);
        end
        rank_new_c[slot_c*RankW +: RankW] = '0;
      end else begin
        rank_new_c[slot_c*RankW +: RankW] = full_c ? RankW'(WAYS-1) : RankW'(n_c);
      end
      vld_new_c[slot_c] = 1'b1;
    end
  end

  // Sequencer and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StClear;
      clr_q   <= '0;
      sel_q   <= dip_pkg::SelMid;
      bip_q   <= '0;
      hits_q  <= '0;
      res_v_q <= 1'b0;
    end else begin
      // Raise the result on execute, drop it once taken.
      if (do_exec) begin
        res_v_q <= 1'b1;
      end else if (res_ready_i) begin
        res_v_q <= 1'b0;
      end
      unique case (st_q)
        StClear: begin
          clr_q <= clr_q + SET_BITS'(1);
          if (clr_q == SET_BITS'(NUM_SETS-1)) st_q <= StIdle;
        end
        StIdle: if (q_valid_i) st_q <= StRead;
        StRead: begin
          if (do_exec) begin
            st_q    <= StIdle;
            if (hit_c) begin
              hits_q <= hits_q + 1'b1;
            end else begin
              if (bip_c) bip_q <= bip_next_c;
              if (role_q == dip_pkg::ROLE_LRU_LDR && sel_q != dip_pkg::SelMax)
                sel_q <= sel_q + 1'b1;
              else if (role_q == dip_pkg::ROLE_BIP_LDR && sel_q != '0)
                sel_q <= sel_q - 1'b1;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // Memories, latched payload and result.
  always_ff @(posedge clk_i) begin
    if (st_q == StClear) begin
      vld_mem[clr_q]  <= '0;
      rank_mem[clr_q] <= '0;
    end else if (do_exec) begin
      vld_mem[set_q]  <= vld_new_c;
      rank_mem[set_q] <= rank_new_c;
      if (!hit_c) tag_mem[set_q][slot_c*TAG_W +: TAG_W] <= tag_q;
    end
    if (q_pop_o) begin
      set_q      <= q_set_i;
      tag_q      <= q_tag_i;
      role_q     <= q_role_i;
      tag_row_q  <= tag_mem[q_set_i];
      rank_row_q <= rank_mem[q_set_i];
      vld_row_q  <= vld_mem[q_set_i];
    end
    if (do_exec) begin
      res_q.hit       <= hit_c;
      res_q.used_bip  <= bip_c;
      res_q.hit_count <= hits_q + dip_pkg::HitCntW'(hit_c);
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StClear) |-> !q_pop_o)
    else $error("pop during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !res_ready_i) |=> $stable(hits_q))
    else $error("hit count moved while result stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_exec |=> res_v_q)
    else $error("executed item gave no result");

endmodule

/* sv/dip_cache_replacement.sv */
// Top level: DIP set-dueling cache replacement lookup.
// Path from accepted address to result: queue entry, queue pop with set row read, update.
// The back end finishes one item (set row read, then write) before it pops the next.
// A 2-entry queue lets the front keep accepting while the back or output stalls.
// Reset (async, active low) clears counters (selector to its midpoint); then a clearing
// pass over all NUM_SETS sets zeroes valid and rank rows, while no item leaves the queue.
module dip_cache_replacement #(
  parameter int unsigned NUM_SETS    = 1024,
  parameter int unsigned WAYS        = 16,
  parameter int unsigned OFFSET_BITS = 6,
  parameter int unsigned ADDR_BITS   = 48
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dip_addr_if.sink in_if,
  dip_res_if.source out_if
);

  localparam int unsigned SetBits = $clog2(NUM_SETS);
  localparam int unsigned TagW    = ADDR_BITS - OFFSET_BITS - SetBits;

  logic                 q_valid, q_pop;
  logic [SetBits-1:0]   q_set;
  logic [TagW-1:0]      q_tag;
  dip_pkg::role_e       q_role;
  dip_pkg::result_t     res;

  dip_front #(
    .ADDR_BITS(ADDR_BITS), .OFFSET_BITS(OFFSET_BITS), .SET_BITS(SetBits), .TAG_W(TagW)
  ) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_addr_i(in_if.address),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_set_o(q_set), .q_tag_o(q_tag),
    .q_role_o(q_role)
  );

  dip_back #(
    .NUM_SETS(NUM_SETS), .WAYS(WAYS), .SET_BITS(SetBits), .TAG_W(TagW)
  ) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_set_i(q_set), .q_tag_i(q_tag),
    .q_role_i(q_role),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(res)
  );

  assign out_if.hit       = res.hit;
  assign out_if.used_bip  = res.used_bip;
  assign out_if.hit_count = res.hit_count;

endmodule

/* tb/tb.sv */
// Testbench for the DIP set-dueling cache replacement block.
module tb;

  localparam int unsigned NSETS  = 1024;
  localparam int unsigned NWAYS  = 16;
  localparam int unsigned OFFB   = 6;
  localparam int unsigned ABITS  = 48;
  localparam int unsigned SETB   = 10;
  localparam int unsigned TAGW   = ABITS - OFFB - SETB;
  localparam int unsigned RANDN  = 1300;
  localparam int unsigned CYCMAX = 400000;

  logic clk_i;
  logic rst_ni;

  dip_addr_if #(.ADDR_BITS(ABITS)) in_if ();
  dip_res_if out_if ();

  dip_cache_replacement #(
    .NUM_SETS(NSETS), .WAYS(NWAYS), .OFFSET_BITS(OFFB), .ADDR_BITS(ABITS)
  ) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if.sink), .out_if(out_if.source)
  );

  // Cache state as predicted.
  logic [TAGW-1:0] line_tag [NSETS][NWAYS];
  logic            line_vld [NSETS][NWAYS];
  logic [3:0]      line_rank[NSETS][NWAYS];
  logic [dip_pkg::SelW-1:0] sel_cnt;
  logic [dip_pkg::BipW-1:0] bip_cnt;
  logic [31:0]     hits_seen;

  logic [ABITS-1:0] addr_q[$];
  dip_pkg::result_t lookup_q[$];
  int unsigned      cycle_cnt;
  int unsigned      fail_cnt;
  bit               calm;
  bit               drv_done;

  // Predict the result of one access and update the cache state.
  function automatic dip_pkg::result_t predict_access(logic [ABITS-1:0] a);
    logic [SETB-1:0] set;
    logic [TAGW-1:0] tg;
    dip_pkg::role_e  role;
    logic            bip;
    int              found;
    int              n;
    int              slot;
    logic [3:0]      r;
    logic            at_mru;
    dip_pkg::result_t res;
    set = a[OFFB +: SETB];
    tg  = a[ABITS-1 -: TAGW];
    role = (set[4:0] == 5'd0) ? dip_pkg::ROLE_LRU_LDR :
           (set[4:0] == 5'd1) ? dip_pkg::ROLE_BIP_LDR : dip_pkg::ROLE_FOLLOW;
    bip = (role == dip_pkg::ROLE_BIP_LDR) ||
          (role == dip_pkg::ROLE_FOLLOW && sel_cnt > dip_pkg::SelMid);
    found = -1;
    n = 0;
    slot = NWAYS;
    for (int w = 0; w < NWAYS; w++)
      if (line_vld[set][w]) begin
        n++;
        if (line_tag[set][w] == tg) found = w;
      end
    if (found >= 0) begin
      r = line_rank[set][found];
      for (int w = 0; w < NWAYS; w++)
        if (line_vld[set][w] && line_rank[set][w] < r) line_rank[set][w]++;
      line_rank[set][found] = 0;
      hits_seen++;
    end else begin
      if (n >= NWAYS) begin
        for (int w = 0; w < NWAYS; w++)
          if (line_rank[set][w] == 4'(NWAYS - 1)) slot = w;
        if (slot >= NWAYS) slot = 0;
        line_vld[set][slot] = 1'b0;
        n = NWAYS - 1;
      end else begin
        for (int w = NWAYS - 1; w >= 0; w--)
          if (!line_vld[set][w]) slot = w;
      end
      at_mru = 1'b1;
      if (bip) begin
        bip_cnt++;
        at_mru = (bip_cnt == '0);
      end
      if (at_mru) begin
        for (int w = 0; w < NWAYS; w++)
          if (line_vld[set][w]) line_rank[set][w]++;
        line_rank[set][slot] = 0;
      end else begin
        line_rank[set][slot] = 4'(n);
      end
      line_tag[set][slot] = tg;
      line_vld[set][slot] = 1'b1;
      if (role == dip_pkg::ROLE_LRU_LDR && sel_cnt < dip_pkg::SelMax) sel_cnt++;
      if (role == dip_pkg::ROLE_BIP_LDR && sel_cnt > 0) sel_cnt--;
    end
    res.hit = (found >= 0);
    res.used_bip = bip;
    res.hit_count = hits_seen;
    return res;
  endfunction

  // Build an address from set and tag with random offset bits.
  function automatic logic [ABITS-1:0] mk_addr(int unsigned set, logic [TAGW-1:0] tg);
    logic [ABITS-1:0] a;
    a = {tg, SETB'(set), OFFB'($urandom)};
    return a;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fill the address queue: directed part, then random working sets.
  initial begin
    int unsigned set;
    int unsigned sets[4];
    logic [TAGW-1:0] tags[24];
    rst_ni = 1'b0;
    for (int w = 0; w < NSETS; w++)
      for (int k = 0; k < NWAYS; k++) begin
        line_vld[w][k] = 1'b0;
        line_rank[w][k] = '0;
        line_tag[w][k] = '0;
      end
    sel_cnt = dip_pkg::SelMid;
    bip_cnt = '0;
    hits_seen = '0;
    addr_q.push_back('0);
    addr_q.push_back('1);
    addr_q.push_back('0);
    addr_q.push_back('1);
    addr_q.push_back({TAGW'(32'h5555_5555), SETB'(1), OFFB'(0)});
    addr_q.push_back({TAGW'(32'hAAAA_AAAA), SETB'(33), OFFB'(63)});
    // Fill a follower set past capacity and revisit the sixth line.
    for (int k = 0; k < 18; k++) addr_q.push_back(mk_addr(2, TAGW'(k)));
    addr_q.push_back(mk_addr(2, TAGW'(5)));
    // Random part: mostly reuse of small tag pools in a few sets per burst.
    while (addr_q.size() < 25 + RANDN) begin
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(0, 3))
          0: sets[s] = $urandom_range(0, 31) * 32;
          1: sets[s] = $urandom_range(0, 31) * 32 + 1;
          default: sets[s] = $urandom_range(0, NSETS - 1);
        endcase
      end
      for (int k = 0; k < 24; k++) tags[k] = TAGW'($urandom);
      for (int j = 0; j < 60; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          addr_q.push_back(ABITS'({$urandom, $urandom}));
        end else begin
          set = sets[$urandom_range(0, 3)];
          addr_q.push_back(mk_addr(set, tags[$urandom_range(0, 23)]));
        end
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Calm window: while the cycle count is in its set range, drive and accept without random gaps.
  always_ff @(posedge clk_i) begin
    calm <= (cycle_cnt > 3000 && cycle_cnt < 6000);
  end

  // Drive addresses from the queue and predict on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.address <= '0;
      drv_done      <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        lookup_q.push_back(predict_access(in_if.address));
        void'(addr_q.pop_front());
      end
      if (in_if.valid && !in_if.ready) begin
        in_if.valid <= 1'b1;
      end else if (addr_q.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
        in_if.valid   <= 1'b1;
        in_if.address <= addr_q[0];
      end else begin
        in_if.valid <= 1'b0;
      end
      drv_done <= (addr_q.size() == 0);
    end
  end

  // Check results against the oldest prediction; stall the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    dip_pkg::result_t exp_r;
    int unsigned      errs;
    errs = 0;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      cycle_cnt    <= 0;
      fail_cnt     <= 0;
    end else begin
      cycle_cnt    <= cycle_cnt + 1;
      out_if.ready <= calm || ($urandom_range(0, 99) >= 16);
      if (out_if.valid && out_if.ready) begin
        if (lookup_q.size() == 0) begin
          $error("unexpected result item");
          errs++;
        end else begin
          exp_r = lookup_q.pop_front();
          if (out_if.hit !== exp_r.hit) begin
            $error("hit: expected %0d actual %0d", exp_r.hit, out_if.hit);
            errs++;
          end
          if (out_if.used_bip !== exp_r.used_bip) begin
            $error("used_bip: expected %0d actual %0d", exp_r.used_bip, out_if.used_bip);
            errs++;
          end
          if (out_if.hit_count !== exp_r.hit_count) begin
            $error("hit_count: expected %0d actual %0d", exp_r.hit_count,
                   out_if.hit_count);
            errs++;
          end
        end
      end
      fail_cnt <= fail_cnt + errs;
    end
  end

  // Wait for drain, settle, and report.
  initial begin
    wait (rst_ni === 1'b1);
    while (!(drv_done && lookup_q.size() == 0) && cycle_cnt < CYCMAX)
      @(posedge clk_i);
    if (cycle_cnt >= CYCMAX) begin
      $display("Test completed with failures");
    end else begin
      repeat (10) @(posedge clk_i);
      if (fail_cnt == 0 && lookup_q.size() == 0) begin
        $display("Test completed successfully");
      end else begin
        $display("Test completed with failures");
      end
    end
    $finish;
  end

endmodule
